// ===== hw/rtl/fbpfl_pkg.sv =====
// Package for the fixed block pool free list.
// Holds the link entry type, request and status codes, and the store geometry.
// No dependencies.
package fbpfl_pkg;

    localparam int unsigned IDX_W       = 8;
    localparam int unsigned STORE_DEPTH = 256;
    localparam int unsigned COUNT_W     = 9;
    localparam int unsigned STATUS_W    = 2;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic null_bit;
        idx_t idx;
    } link_t;

    localparam int unsigned LINK_W = $bits(link_t);

    localparam link_t LINK_NULL = '{null_bit: 1'b1, idx: '0};

    typedef enum logic [1:0] {
        REQ_ALLOC    = 2'd0,
        REQ_FREE     = 2'd1,
        REQ_READ_LINK = 2'd2,
        REQ_SET_LINK = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_POOL_EMPTY = 2'd1,
        ST_NULL_CHUNK = 2'd2
    } status_t;

    typedef struct packed {
        logic    link_null;
        idx_t    link_index;
        logic    chunk_null;
        idx_t    chunk_index;
        req_t    req_type;
    } req_item_t;

    typedef struct packed {
        status_t status;
        logic    result_null;
        idx_t    result_index;
    } rsp_item_t;

endpackage

// ===== hw/rtl/fbpfl_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Used for the link store of the free list. No dependencies.
module fbpfl_ram #(
    parameter int unsigned WIDTH = 9,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/fixed_block_pool_free_list.sv =====
// Top level of the fixed block pool free list.
// Depends on fbpfl_pkg and fbpfl_ram.
//
// Usage:
//   The s_ channel takes one request per transaction: alloc, free, read link
//   or set link. The m_ channel returns exactly one response per request, in
//   order: a chunk index, a null flag and a status code.
//   cfg_we/cfg_wdata write chunk_count (clamped to 1..MAX_CHUNKS) and rebuild
//   the free chain 0, 1, ..., count-1 with the head at chunk 0. Write it only
//   while no request is in flight.
// Pipeline and throughput:
//   Requests pass the execute register, then the output register. One request
//   per cycle is sustained while m_tready is high: the link store read is
//   issued at the accept edge, the executing request's new head is forwarded
//   to the read address, and its store write is bypassed to a read of that entry.
// Reset:
//   chunk_count returns to MAX_CHUNKS and the chain is rebuilt at once: a
//   per-entry valid bit makes unwritten entries read their chain value.
// Stall:
//   With m_tready low both registers hold; s_tready drops once both are full.
module fixed_block_pool_free_list #(
    parameter int unsigned MAX_CHUNKS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: req_type[1:0], chunk_index[9:2], chunk_null[10],
    //          link_index[18:11], link_null[19], zero fill[23:20]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    // m_tdata: result_index[7:0], result_null[8], status[10:9],
    //          zero fill[15:11]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata
);

    localparam int unsigned REQ_BITS = $bits(fbpfl_pkg::req_item_t);
    localparam int unsigned RSP_BITS = $bits(fbpfl_pkg::rsp_item_t);

    // Control and state
    logic                                   ex_valid_reg, ex_valid_next;
    logic                                   out_valid_reg, out_valid_next;
    fbpfl_pkg::link_t                       head_reg, head_next;
    logic [fbpfl_pkg::COUNT_W-1:0]          count_reg, count_next;
    logic [fbpfl_pkg::STORE_DEPTH-1:0]      vld_reg, vld_next;

    // Executing request
    fbpfl_pkg::req_item_t                   ex_req_reg;
    fbpfl_pkg::idx_t                        ex_addr_reg;
    logic                                   ex_vld_reg;
    logic                                   ex_byp_reg;
    fbpfl_pkg::link_t                       ex_byp_data_reg;

    fbpfl_pkg::rsp_item_t                   out_reg, rsp;

    fbpfl_pkg::req_item_t                   in_req;
    logic                                   accept, ex_adv, ex_fire;
    fbpfl_pkg::idx_t                        rd_addr;
    fbpfl_pkg::link_t                       head_fwd;

    logic                                   we;
    fbpfl_pkg::idx_t                        waddr;
    fbpfl_pkg::link_t                       wdata;
    logic [fbpfl_pkg::LINK_W-1:0]           ram_q;
    fbpfl_pkg::link_t                       entry, reset_entry;
    logic [fbpfl_pkg::COUNT_W-1:0]          addr_plus1;
    logic [fbpfl_pkg::COUNT_W-1:0]          cfg_clamped;
    logic                                   wr_hit;

    assign in_req   = fbpfl_pkg::req_item_t'(s_tdata[REQ_BITS-1:0]);
    assign ex_adv   = !out_valid_reg || m_tready;
    assign ex_fire  = ex_valid_reg && ex_adv;
    assign s_tready = !ex_valid_reg || ex_adv;
    assign accept   = s_tvalid && s_tready;

    // Alloc reads the entry at the head as it stands after the executing request
    assign head_fwd = ex_fire ? head_next : head_reg;
    assign rd_addr  = (in_req.req_type == fbpfl_pkg::REQ_ALLOC) ? head_fwd.idx
                                                                : in_req.chunk_index;
    assign wr_hit   = ex_fire && we && (waddr == rd_addr);

    fbpfl_ram #(
        .WIDTH(fbpfl_pkg::LINK_W),
        .DEPTH(fbpfl_pkg::STORE_DEPTH)
    ) u_link_store (
        .aclk (aclk),
        .we   (ex_fire && we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (accept),
        .raddr(rd_addr),
        .rdata(ram_q)
    );

    // Unwritten entries read as their place in the rebuilt chain
    assign addr_plus1  = {1'b0, ex_addr_reg} + fbpfl_pkg::COUNT_W'(1);
    assign reset_entry = (addr_plus1 < count_reg)
                       ? '{null_bit: 1'b0, idx: addr_plus1[fbpfl_pkg::IDX_W-1:0]}
                       : fbpfl_pkg::LINK_NULL;

    always_comb begin
        priority if (ex_byp_reg) begin
            entry = ex_byp_data_reg;
        end else if (ex_vld_reg) begin
            entry = fbpfl_pkg::link_t'(ram_q);
        end else begin
            entry = reset_entry;
        end
    end

    // Execute
    always_comb begin
        rsp       = '{status: fbpfl_pkg::ST_OK, result_null: 1'b0, result_index: '0};
        head_next = head_reg;
        we        = 1'b0;
        waddr     = ex_req_reg.chunk_index;
        wdata     = fbpfl_pkg::LINK_NULL;
        priority if (ex_req_reg.req_type == fbpfl_pkg::REQ_ALLOC) begin
            if (head_reg.null_bit) begin
                rsp.status      = fbpfl_pkg::ST_POOL_EMPTY;
                rsp.result_null = 1'b1;
            end else begin
                rsp.result_index = head_reg.idx;
                head_next        = entry;
                we               = 1'b1;
                waddr            = head_reg.idx;
                wdata            = fbpfl_pkg::LINK_NULL;
            end
        end else if (ex_req_reg.chunk_null) begin
            rsp.status      = fbpfl_pkg::ST_NULL_CHUNK;
            rsp.result_null = 1'b1;
        end else begin
            unique case (ex_req_reg.req_type)
                fbpfl_pkg::REQ_FREE: begin
                    we        = 1'b1;
                    wdata     = head_reg;
                    head_next = '{null_bit: 1'b0, idx: ex_req_reg.chunk_index};
                end
                fbpfl_pkg::REQ_READ_LINK: begin
                    rsp.result_null  = entry.null_bit;
                    rsp.result_index = entry.null_bit ? '0 : entry.idx;
                end
                fbpfl_pkg::REQ_SET_LINK: begin
                    we    = 1'b1;
                    wdata = ex_req_reg.link_null
                          ? fbpfl_pkg::LINK_NULL
                          : '{null_bit: 1'b0, idx: ex_req_reg.link_index};
                    rsp.result_index = ex_req_reg.chunk_index;
                end
                default: begin
                    rsp = rsp;
                end
            endcase
        end
    end

    always_comb begin
        cfg_clamped = cfg_wdata;
        if (cfg_wdata == '0) begin
            cfg_clamped = fbpfl_pkg::COUNT_W'(1);
        end else if (cfg_wdata > fbpfl_pkg::COUNT_W'(MAX_CHUNKS)) begin
            cfg_clamped = fbpfl_pkg::COUNT_W'(MAX_CHUNKS);
        end
    end

    always_comb begin
        ex_valid_next  = ex_valid_reg;
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        vld_next       = vld_reg;
        if (ex_fire) begin
            ex_valid_next = 1'b0;
        end
        if (accept) begin
            ex_valid_next = 1'b1;
        end
        if (ex_fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (ex_fire && we) begin
            vld_next[waddr] = 1'b1;
        end
        if (cfg_we) begin
            count_next = cfg_clamped;
            vld_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= fbpfl_pkg::COUNT_W'(MAX_CHUNKS);
            vld_reg       <= '0;
            head_reg      <= '{null_bit: 1'b0, idx: '0};
        end else begin
            ex_valid_reg  <= ex_valid_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            vld_reg       <= vld_next;
            if (cfg_we) begin
                head_reg <= '{null_bit: 1'b0, idx: '0};
            end else if (ex_fire) begin
                head_reg <= head_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            ex_req_reg      <= in_req;
            ex_addr_reg     <= rd_addr;
            ex_vld_reg      <= vld_reg[rd_addr] || wr_hit;
            ex_byp_reg      <= wr_hit;
            ex_byp_data_reg <= wdata;
        end
        if (ex_fire) begin
            out_reg <= rsp;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16 - RSP_BITS){1'b0}}, out_reg};

    // Checks
    a_err_is_null: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.status != fbpfl_pkg::ST_OK) |->
            (out_reg.result_null && out_reg.result_index == '0))
        else $error("error response without null result");

    a_cfg_head: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> (head_reg.null_bit == 1'b0 && head_reg.idx == '0 && vld_reg == '0))
        else $error("chain not rebuilt after chunk_count write");

    a_ex_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (ex_valid_reg && !ex_adv) |=> (ex_valid_reg && $stable(ex_req_reg)))
        else $error("stalled request lost");

    a_wr_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (ex_fire && we && !cfg_we) |=> vld_reg[$past(waddr)])
        else $error("written entry not marked valid");

    a_alloc_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (ex_fire && ex_req_reg.req_type == fbpfl_pkg::REQ_ALLOC && !head_reg.null_bit)
            |=> (m_tvalid && out_reg.status == fbpfl_pkg::ST_OK && !out_reg.result_null))
        else $error("alloc from non-empty pool failed");

endmodule

// ===== tb/sv/fixed_block_pool_free_list_checker.sv =====
// Response checker for the fixed block pool free list.
// Watches the request, response and configuration ports, predicts each response
// with its own copy of the pool state, and compares. Depends on fbpfl_pkg.
`timescale 1ns / 100ps

module fixed_block_pool_free_list_checker #(
    parameter int unsigned MAX_CHUNKS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    output int          mismatch_count,
    output int          rsp_outstanding,
    output int          rsp_checked
);

    fbpfl_pkg::link_t     chain_links [fbpfl_pkg::STORE_DEPTH];
    fbpfl_pkg::link_t     chain_head;
    fbpfl_pkg::rsp_item_t expected_rsps [$];
    fbpfl_pkg::rsp_item_t got_rsp;
    fbpfl_pkg::rsp_item_t want_rsp;
    int                   mismatches = 0;
    int                   checked = 0;

    function automatic logic [fbpfl_pkg::COUNT_W-1:0] clamp_count(
        logic [fbpfl_pkg::COUNT_W-1:0] v);
        if (v == 0) begin
            return fbpfl_pkg::COUNT_W'(1);
        end
        if (v > MAX_CHUNKS) begin
            return fbpfl_pkg::COUNT_W'(MAX_CHUNKS);
        end
        return v;
    endfunction

    // Chain 0 -> 1 -> ... -> n-1 -> null; every entry from n-1 up is null.
    function automatic void rebuild_chain(logic [fbpfl_pkg::COUNT_W-1:0] n);
        for (int i = 0; i < fbpfl_pkg::STORE_DEPTH; i++) begin
            if (i + 1 < n) begin
                chain_links[i] = '{null_bit: 1'b0, idx: fbpfl_pkg::idx_t'(i + 1)};
            end else begin
                chain_links[i] = fbpfl_pkg::LINK_NULL;
            end
        end
        chain_head = '{null_bit: 1'b0, idx: '0};
    endfunction

    function automatic fbpfl_pkg::rsp_item_t pool_step(fbpfl_pkg::req_item_t rq);
        fbpfl_pkg::rsp_item_t rsp;
        fbpfl_pkg::link_t     entry;
        fbpfl_pkg::idx_t      popped;
        rsp = '{status: fbpfl_pkg::ST_OK, result_null: 1'b0, result_index: '0};
        if (rq.req_type == fbpfl_pkg::REQ_ALLOC) begin
            if (chain_head.null_bit) begin
                rsp.status      = fbpfl_pkg::ST_POOL_EMPTY;
                rsp.result_null = 1'b1;
            end else begin
                popped              = chain_head.idx;
                chain_head          = chain_links[popped];
                chain_links[popped] = fbpfl_pkg::LINK_NULL;
                rsp.result_index    = popped;
            end
        end else if (rq.chunk_null) begin
            rsp.status      = fbpfl_pkg::ST_NULL_CHUNK;
            rsp.result_null = 1'b1;
        end else begin
            case (rq.req_type)
                fbpfl_pkg::REQ_FREE: begin
                    chain_links[rq.chunk_index] = chain_head;
                    chain_head = '{null_bit: 1'b0, idx: rq.chunk_index};
                end
                fbpfl_pkg::REQ_READ_LINK: begin
                    entry = chain_links[rq.chunk_index];
                    if (entry.null_bit) begin
                        rsp.result_null = 1'b1;
                    end else begin
                        rsp.result_index = entry.idx;
                    end
                end
                default: begin
                    if (rq.link_null) begin
                        chain_links[rq.chunk_index] = fbpfl_pkg::LINK_NULL;
                    end else begin
                        chain_links[rq.chunk_index] = '{null_bit: 1'b0, idx: rq.link_index};
                    end
                    rsp.result_index = rq.chunk_index;
                end
            endcase
        end
        return rsp;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t checker: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            rebuild_chain(fbpfl_pkg::COUNT_W'(MAX_CHUNKS));
            expected_rsps.delete();
        end else begin
            if (cfg_we) begin
                rebuild_chain(clamp_count(cfg_wdata));
            end
            // Retire the response before queuing a new request in the same cycle.
            if (m_tvalid && m_tready) begin
                got_rsp = fbpfl_pkg::rsp_item_t'(m_tdata[$bits(fbpfl_pkg::rsp_item_t)-1:0]);
                if (expected_rsps.size() == 0) begin
                    report_mismatch($sformatf("response with no request pending, data %h",
                                              m_tdata));
                end else begin
                    want_rsp = expected_rsps.pop_front();
                    if (got_rsp.result_index !== want_rsp.result_index) begin
                        report_mismatch($sformatf("response %0d result_index %0d, want %0d",
                            checked, got_rsp.result_index, want_rsp.result_index));
                    end
                    if (got_rsp.result_null !== want_rsp.result_null) begin
                        report_mismatch($sformatf("response %0d result_null %0d, want %0d",
                            checked, got_rsp.result_null, want_rsp.result_null));
                    end
                    if (got_rsp.status !== want_rsp.status) begin
                        report_mismatch($sformatf("response %0d status %0d, want %0d",
                            checked, got_rsp.status, want_rsp.status));
                    end
                    checked++;
                end
            end
            if (s_tvalid && s_tready) begin
                expected_rsps.push_back(pool_step(
                    fbpfl_pkg::req_item_t'(s_tdata[$bits(fbpfl_pkg::req_item_t)-1:0])));
            end
        end
        mismatch_count  <= mismatches;
        rsp_outstanding <= expected_rsps.size();
        rsp_checked     <= checked;
    end

endmodule

// ===== tb/sv/fixed_block_pool_free_list_tb.sv =====
// Testbench top for the fixed block pool free list: drives requests, chunk_count
// writes and response back-pressure, and reports the verdict.
// Depends on fbpfl_pkg, fixed_block_pool_free_list and its checker module.
`timescale 1ns / 100ps

module fixed_block_pool_free_list_tb;

    localparam int unsigned MAX_CHUNKS     = 256;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          BLOCK_ITEMS    = 80;
    localparam int          NUM_BLOCKS     = 12;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [8:0]  cfg_wdata = '0;

    int mismatch_count;
    int rsp_outstanding;
    int rsp_checked;

    int tx_idle_pct = 16;
    int rx_idle_pct = 84;
    int stall_cycles = 0;
    int reqs_sent = 0;
    int count_writes = 0;
    int live_count = MAX_CHUNKS;

    logic [fbpfl_pkg::COUNT_W-1:0] block_counts [NUM_BLOCKS] =
        '{1, 256, 5, 0, 2, 17, 511, 100, 3, 256, 1, 60};

    fixed_block_pool_free_list #(
        .MAX_CHUNKS(MAX_CHUNKS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    fixed_block_pool_free_list_checker #(
        .MAX_CHUNKS(MAX_CHUNKS)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .rsp_outstanding(rsp_outstanding),
        .rsp_checked    (rsp_checked)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // End the run when no transaction moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", stall_cycles);
            $display("fixed_block_pool_free_list: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic fbpfl_pkg::req_item_t mk_req(fbpfl_pkg::req_t op, int unsigned chunk,
                                                    bit cnull, int unsigned link, bit lnull);
        fbpfl_pkg::req_item_t rq;
        rq.req_type    = op;
        rq.chunk_index = fbpfl_pkg::idx_t'(chunk);
        rq.chunk_null  = cnull;
        rq.link_index  = fbpfl_pkg::idx_t'(link);
        rq.link_null   = lnull;
        return rq;
    endfunction

    // Mostly chunks inside the live pool, now and then any 8-bit index.
    function automatic int unsigned pick_chunk(int n);
        if ($urandom_range(9) == 0) begin
            return $urandom_range(255);
        end
        return $urandom_range(n - 1);
    endfunction

    function automatic fbpfl_pkg::req_item_t rand_req(int n);
        int              w;
        fbpfl_pkg::req_t op;
        w = $urandom_range(99);
        if (w < 40) begin
            op = fbpfl_pkg::REQ_ALLOC;
        end else if (w < 65) begin
            op = fbpfl_pkg::REQ_FREE;
        end else if (w < 82) begin
            op = fbpfl_pkg::REQ_READ_LINK;
        end else begin
            op = fbpfl_pkg::REQ_SET_LINK;
        end
        return mk_req(op, pick_chunk(n), ($urandom_range(15) == 0), pick_chunk(n),
                      ($urandom_range(3) == 0));
    endfunction

    task automatic send_req(fbpfl_pkg::req_item_t rq);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, rq};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        reqs_sent++;
    endtask

    // Drain every response, let the pipeline settle, then write chunk_count.
    task automatic write_count(logic [fbpfl_pkg::COUNT_W-1:0] v);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (rsp_outstanding != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        count_writes++;
        if (v == 0) begin
            live_count = 1;
        end else if (v > MAX_CHUNKS) begin
            live_count = MAX_CHUNKS;
        end else begin
            live_count = v;
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset chain of 256 chunks.
        send_req(mk_req(fbpfl_pkg::REQ_ALLOC, 0, 0, 0, 0));
        send_req(mk_req(fbpfl_pkg::REQ_ALLOC, 0, 0, 0, 0));
        send_req(mk_req(fbpfl_pkg::REQ_READ_LINK, 0, 0, 0, 0));
        send_req(mk_req(fbpfl_pkg::REQ_READ_LINK, 254, 0, 0, 0));
        send_req(mk_req(fbpfl_pkg::REQ_READ_LINK, 255, 0, 0, 0));
        send_req(mk_req(fbpfl_pkg::REQ_FREE, 0, 0, 0, 0));
        send_req(mk_req(fbpfl_pkg::REQ_ALLOC, 0, 0, 0, 0));
        send_req(mk_req(fbpfl_pkg::REQ_FREE, 255, 1, 255, 1));
        send_req(mk_req(fbpfl_pkg::REQ_READ_LINK, 0, 1, 0, 0));
        send_req(mk_req(fbpfl_pkg::REQ_SET_LINK, 9, 1, 4, 0));
        send_req(mk_req(fbpfl_pkg::REQ_SET_LINK, 255, 0, 0, 0));
        send_req(mk_req(fbpfl_pkg::REQ_SET_LINK, 7, 0, 255, 1));
        send_req(mk_req(fbpfl_pkg::REQ_READ_LINK, 7, 0, 0, 0));
        send_req(mk_req(fbpfl_pkg::REQ_SET_LINK, 200, 0, 255, 0));
        send_req(mk_req(fbpfl_pkg::REQ_READ_LINK, 200, 0, 0, 0));
        send_req(mk_req(fbpfl_pkg::REQ_ALLOC, 255, 1, 255, 1));

        // Single chunk pool: empty pool, index beyond the count, double free.
        write_count(1);
        send_req(mk_req(fbpfl_pkg::REQ_ALLOC, 0, 0, 0, 0));
        send_req(mk_req(fbpfl_pkg::REQ_ALLOC, 0, 0, 0, 0));
        send_req(mk_req(fbpfl_pkg::REQ_FREE, 255, 0, 0, 0));
        send_req(mk_req(fbpfl_pkg::REQ_ALLOC, 0, 0, 0, 0));
        send_req(mk_req(fbpfl_pkg::REQ_ALLOC, 0, 0, 0, 0));
        send_req(mk_req(fbpfl_pkg::REQ_FREE, 0, 0, 0, 0));
        send_req(mk_req(fbpfl_pkg::REQ_FREE, 0, 0, 0, 0));
        send_req(mk_req(fbpfl_pkg::REQ_ALLOC, 0, 0, 0, 0));
        send_req(mk_req(fbpfl_pkg::REQ_ALLOC, 0, 0, 0, 0));

        block_counts[7]  = fbpfl_pkg::COUNT_W'($urandom_range(255, 2));
        block_counts[11] = fbpfl_pkg::COUNT_W'($urandom_range(255, 2));
        for (int b = 0; b < NUM_BLOCKS; b++) begin
            // Receiver sparse first, then sender sparse, then no idling at all.
            if (b == NUM_BLOCKS / 3) begin
                tx_idle_pct = 84;
                rx_idle_pct = 16;
            end else if (b == 2 * NUM_BLOCKS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_count(block_counts[b]);
            for (int k = 0; k < BLOCK_ITEMS; k++) begin
                send_req(rand_req(live_count));
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (rsp_outstanding != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);

        $display("fixed_block_pool_free_list_tb: %0d requests, %0d responses checked, %0d %s",
                 reqs_sent, rsp_checked, count_writes, "chunk_count writes");
        $display("fixed_block_pool_free_list_tb: all four operations, null chunks, %s",
                 "empty pools and counts 1 to 256 under three back-pressure mixes");
        if (mismatch_count == 0) begin
            $display("fixed_block_pool_free_list: match");
        end else begin
            $display("fixed_block_pool_free_list: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/fbpfl_pkg.sv
hw/rtl/fbpfl_ram.sv
hw/rtl/fixed_block_pool_free_list.sv
tb/sv/fixed_block_pool_free_list_checker.sv
tb/sv/fixed_block_pool_free_list_tb.sv
